// File: rtl/hkv_pkg.sv
// Package for the hashed key-value store: sizes, codes and shared types.
// Has no dependencies; every other file of the block but hkv_ram imports it.
`timescale 1ns / 1ps

package hkv_pkg;

    // Table geometry.
    localparam int BUCKETS          = 10;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int TOTAL_SLOTS      = BUCKETS * SLOTS_PER_BUCKET;

    // Field widths.
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    // Derived widths.
    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int ADDR_W   = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int ENTRY_W  = KEY_W + VALUE_W;

    // Reciprocal for the bucket index: quotient = (key * MOD_MAGIC) >> MOD_SHIFT,
    // exact for every key of KEY_W bits.
    localparam int MOD_SHIFT = KEY_W + $clog2(BUCKETS);
    localparam int MAGIC_W   = KEY_W + 1;
    localparam int PROD_W    = KEY_W + MAGIC_W;
    localparam int QUOT_W    = PROD_W - MOD_SHIFT;
    localparam logic [MAGIC_W-1:0] MOD_MAGIC =
        MAGIC_W'(((64'd1 << MOD_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // Request to the remainder unit.
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
    } mod_req_t;

    // Answer of the remainder unit.
    typedef struct packed {
        logic                done;
        logic [BUCKET_W-1:0] rem;
    } mod_rsp_t;

endpackage

// File: rtl/hkv_if.sv
// Handshake interfaces for the request and response channels of the store.
// Depends on hkv_pkg for the field widths.
`timescale 1ns / 1ps

interface hkv_req_if import hkv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, mode, key, value, input ready);
    modport sink (input valid, mode, key, value, output ready);
endinterface

interface hkv_rsp_if import hkv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;

    modport source (output valid, status, read_value, input ready);
    modport sink (input valid, status, read_value, output ready);
endinterface

// File: rtl/hkv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; sized by its width and depth parameters.
`timescale 1ns / 1ps

module hkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read data registered on every clock.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/hkv_mod_unit.sv
// Remainder unit: key modulo the bucket count by reciprocal multiplication, in stages.
// Depends on hkv_pkg for widths, the reciprocal constants and the request and answer structs.
`timescale 1ns / 1ps

module hkv_mod_unit import hkv_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    logic                busy_reg;
    logic                sub_reg;
    logic                done_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [BUCKET_W-1:0] rem_reg;
    logic [PROD_W-1:0]   product;
    logic [BUCKET_W-1:0] rem_next;

    // Quotient from a 31 by 32 bit product, remainder by subtracting quotient times buckets.
    always_comb
    begin
        product  = PROD_W'(key_reg) * PROD_W'(MOD_MAGIC);
        rem_next = BUCKET_W'(key_reg - KEY_W'(quot_reg) * KEY_W'(BUCKETS));
    end

    // Staged sequence: multiply, then subtract, then report.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
            key_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= req.start;
            sub_reg  <= busy_reg;
            done_reg <= sub_reg;
            if (req.start)
            begin
                key_reg <= req.key;
            end
            if (busy_reg)
            begin
                quot_reg <= product[PROD_W-1:MOD_SHIFT];
            end
            if (sub_reg)
            begin
                rem_reg <= rem_next;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    // A reported remainder is always below the bucket count.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, rem_reg} < (BUCKET_W + 1)'(BUCKETS)))
        else $error("remainder out of range");

    // At most one stage is active at a time.
    a_stages: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({busy_reg, sub_reg, done_reg}))
        else $error("remainder stages overlap");

    // The unit is never restarted in the middle of a key.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg || sub_reg) |-> !req.start)
        else $error("remainder unit restarted while busy");

endmodule

// File: rtl/hash_table_key_value_store.sv
// Hashed key-value store: insert, find and delete over fixed-size buckets.
// Order: the response is registered directly for an unused mode; otherwise the remainder unit
// picks the bucket, whose slots are read and compared in turn up to a hit or the last slot.
// Throughput: one transaction at a time; the next is accepted once the response is registered.
// Reset clears all slot valid bits at once; key and value RAM contents are not cleared.
// Depends on hkv_pkg, hkv_if, hkv_ram and hkv_mod_unit.
`timescale 1ns / 1ps

module hash_table_key_value_store import hkv_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    hkv_req_if.sink    req,
    hkv_rsp_if.source  rsp
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_WR   = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [MODE_W-1:0]         mode_reg;
    logic [KEY_W-1:0]          key_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [ADDR_W-1:0]         base_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [ADDR_W-1:0]         rd_addr_reg;
    logic                      hit_reg;
    logic [ADDR_W-1:0]         hit_addr_reg;
    logic                      free_found_reg;
    logic [ADDR_W-1:0]         free_addr_reg;
    logic signed [VALUE_W-1:0] found_value_reg;
    logic [TOTAL_SLOTS-1:0]    valid_reg;

    logic                      out_valid_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [VALUE_W-1:0] read_value_reg;

    mod_req_t                  mod_req;
    mod_rsp_t                  mod_rsp;

    logic                      accept;
    logic                      out_free;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [KEY_W-1:0]          entry_key;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      slot_hit;
    logic                      last_slot;

    logic [STATUS_W-1:0]       status_next;
    logic signed [VALUE_W-1:0] read_value_next;
    logic                      set_valid;
    logic                      clr_valid;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Remainder unit that picks the bucket.
    assign mod_req.start = accept && (req.mode != MODE_UNUSED);
    assign mod_req.key   = req.key;

    hkv_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Key and value storage, one entry per slot.
    assign rd_addr = base_reg + ADDR_W'(slot_reg);

    hkv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({key_reg, value_reg}),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign entry_key   = ram_rdata[ENTRY_W-1:VALUE_W];
    assign entry_value = ram_rdata[VALUE_W-1:0];
    assign slot_hit    = valid_reg[rd_addr_reg] && (entry_key == key_reg);
    assign last_slot   = (slot_reg == SLOT_W'(SLOTS_PER_BUCKET - 1));

    // Final decision: status, read value and the table update.
    always_comb
    begin
        status_next     = ST_NOT_FOUND;
        read_value_next = '0;
        ram_we          = 1'b0;
        ram_waddr       = hit_addr_reg;
        set_valid       = 1'b0;
        clr_valid       = 1'b0;
        case (mode_reg)
            MODE_INSERT:
            begin
                if (hit_reg)
                begin
                    status_next = ST_UPDATED;
                    ram_we      = 1'b1;
                end
                else if (free_found_reg)
                begin
                    status_next = ST_INSERTED;
                    ram_we      = 1'b1;
                    ram_waddr   = free_addr_reg;
                    set_valid   = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            MODE_FIND:
            begin
                if (hit_reg)
                begin
                    status_next     = ST_FOUND;
                    read_value_next = found_value_reg;
                end
            end
            MODE_DELETE:
            begin
                if (hit_reg)
                begin
                    status_next = ST_DELETED;
                    clr_valid   = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
        if (!((state_reg == S_WR) && out_free))
        begin
            ram_we    = 1'b0;
            set_valid = 1'b0;
            clr_valid = 1'b0;
        end
    end

    // Sequencer state transitions.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.mode == MODE_UNUSED) ? S_WR : S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = (slot_hit || last_slot) ? S_WR : S_RD;
            end
            S_WR:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and slot valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (state_reg == S_CMP)
            begin
                if (slot_hit)
                begin
                    hit_reg <= 1'b1;
                end
                else if (!valid_reg[rd_addr_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (set_valid)
            begin
                valid_reg[free_addr_reg] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[hit_addr_reg] <= 1'b0;
            end
            if ((state_reg == S_WR) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request fields, scan position and captured results.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= req.mode;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        if ((state_reg == S_MOD) && mod_rsp.done)
        begin
            base_reg <= ADDR_W'(int'(mod_rsp.rem) * SLOTS_PER_BUCKET);
            slot_reg <= '0;
        end
        if (state_reg == S_RD)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (state_reg == S_CMP)
        begin
            if (slot_hit)
            begin
                hit_addr_reg    <= rd_addr_reg;
                found_value_reg <= entry_value;
            end
            else if (!valid_reg[rd_addr_reg] && !free_found_reg)
            begin
                free_addr_reg <= rd_addr_reg;
            end
            if (!last_slot)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
        if ((state_reg == S_WR) && out_free)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.read_value = read_value_reg;

    // Every slot read stays inside the table.
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (rd_addr < ADDR_W'(TOTAL_SLOTS)))
        else $error("slot address beyond the table");

    // A recorded hit points at an occupied slot until the update is made.
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WR) && hit_reg) |-> valid_reg[hit_addr_reg])
        else $error("hit recorded on an empty slot");

    // A recorded free slot is still empty when the insert lands.
    a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WR) && free_found_reg) |-> !valid_reg[free_addr_reg])
        else $error("free slot already occupied");

    // Finishing a transaction always presents a response.
    a_resp_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WR) && out_free) |=> out_valid_reg)
        else $error("finished transaction without a response");

endmodule
